[rtl/prm1d_pkg.sv]
// Shared types, codes and saturation helpers for the 1D return-mapping block.
// No dependencies; the top level, prm1d_ctrl and prm1d_dp import this package.
`default_nettype none
package prm1d_pkg;

    typedef enum logic [1:0] {
        MODE_UPDATE  = 2'd0,
        MODE_COMMIT  = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_INITIAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_ELASTIC = 2'd0,
        CFG_ISO     = 2'd1,
        CFG_KIN     = 2'd2,
        CFG_YIELD   = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRIAL_GO, ST_TRIAL_WAIT, ST_KA_GO, ST_KA_WAIT, ST_CHECK,
        ST_DECIDE, ST_GAM_GO, ST_GAM_WAIT, ST_DS_GO, ST_DS_WAIT, ST_DB_GO,
        ST_DB_WAIT, ST_TM_GO, ST_TM_WAIT, ST_TD_GO, ST_TD_WAIT, ST_ELASTIC,
        ST_MODE, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_MUL_TRIAL, OP_SAVE_TRIAL, OP_MUL_KA, OP_SAVE_KA,
        OP_CHECK, OP_DIV_GAM, OP_SAVE_GAM, OP_MUL_DS, OP_SAVE_DS, OP_MUL_DB,
        OP_SAVE_DB, OP_MUL_TAN, OP_DIV_TAN, OP_PLASTIC, OP_ELASTIC, OP_MODE,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic plastic;
    } status_t;

    localparam int OUT_W = 208;

    // Signed 50-bit value saturated into 48 bits.
    function automatic logic [47:0] sat50_48(input logic [49:0] v);
        logic [47:0] r;
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            r = v[47:0];
        end else begin
            r = v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    // Signed 34-bit value saturated into 32 bits.
    function automatic logic [31:0] sat34_32(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else begin
            r = v[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // min(p >> 28, 2^48) for a product below 2^96.
    function automatic logic [48:0] shr28_cap48(input logic [95:0] p);
        logic [48:0] r;
        if ((|p[95:77]) || (p[76:28] > {1'b1, 48'd0})) begin
            r = {1'b1, 48'd0};
        end else begin
            r = p[76:28];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/plasticity_return_map_1d.sv]
// Top level of the uniaxial return-mapping plasticity block.
// Depends on prm1d_pkg, prm1d_ctrl and prm1d_dp (which holds prm1d_mul and prm1d_div).
//
// Usage. Each input word on the s_ channel carries a mode in s_tuser and a total
// strain in s_tdata. Mode update runs the elastic predictor and, when the yield
// function is positive, the plastic corrector; commit, reverse and initial copy
// or clear the state. Every input word produces exactly one output word on the
// m_ channel holding the state after the step, with the plastic flag in m_tuser.
// Material moduli must be written through the cfg_ port while idle; not enforced.
//
// Sequencing. One word is processed at a time. An update runs two passes of the
// shared shift-and-add multiplier; the plastic branch adds two divider passes and
// three more multiplier passes.
//
// After reset the moduli take their reset values, the state is zero with the
// tangent at 65536, and no output is valid. A finished result sits in an output
// register; when the receiver stalls, it stays there and the block can accept and
// work on the next word, holding its result until the register is free.
`default_nettype none
module plasticity_return_map_1d (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [46:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] total_strain
    input  wire logic [1:0]   s_tuser,   // [1:0] mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [47:0] stress, [94:48] tangent, [126:95] plastic_strain_out,
    // [174:127] back_stress_out, [206:175] hardening_var_out, [207] zero
    output logic [prm1d_pkg::OUT_W-1:0] m_tdata,
    output logic              m_tuser    // [0] yielded
);
    import prm1d_pkg::*;

    cmd_t    cmd;
    status_t status;

    prm1d_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .is_update(s_tuser == MODE_UPDATE),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .status(status)
    );

    prm1d_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_mode(s_tuser), .in_strain(s_tdata),
        .cmd(cmd), .status(status),
        .out_data(m_tdata), .out_yielded(m_tuser)
    );
endmodule
`default_nettype wire

[rtl/prm1d_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, 48 by 48 bits.
// Depends on nothing but the clock and reset.
`default_nettype none
module prm1d_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [47:0] a,
    input  wire logic [47:0] b,
    output logic             done,
    output logic [95:0]      prod
);
    logic [95:0] acc_reg;
    logic [47:0] mcand_reg, mplier_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd47;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= a;
            mplier_reg <= b;
        end else if (busy_reg) begin
            acc_reg    <= {acc_reg[94:0], 1'b0} + (mplier_reg[47] ? {48'd0, mcand_reg} : 96'd0);
            mplier_reg <= {mplier_reg[46:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

[rtl/prm1d_div.sv]
// Restoring divider, one quotient bit per cycle: 96-bit dividend, 49-bit divisor.
// Depends on nothing but the clock and reset.
`default_nettype none
module prm1d_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [95:0] dividend,
    input  wire logic [48:0] divisor,
    output logic             done,
    output logic [95:0]      quot
);
    logic [95:0] sh_reg;
    logic [48:0] rem_reg, d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [49:0] trial;
    logic        fits;

    always_comb begin
        trial = {rem_reg, sh_reg[95]};
        fits  = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd95;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? 49'(trial - {1'b0, d_reg}) : trial[48:0];
            sh_reg  <= {sh_reg[94:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;
endmodule
`default_nettype wire

[rtl/prm1d_ctrl.sv]
// Sequencer of the return mapping: steps the datapath through each item.
// Depends on prm1d_pkg for the state, command and status types.
`default_nettype none
module prm1d_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              is_update,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output prm1d_pkg::cmd_t        cmd,
    input  wire prm1d_pkg::status_t status
);
    import prm1d_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   loading;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = is_update ? ST_TRIAL_GO : ST_MODE;
            ST_TRIAL_GO:   state_next = ST_TRIAL_WAIT;
            ST_TRIAL_WAIT: if (status.mul_done) state_next = ST_KA_GO;
            ST_KA_GO:      state_next = ST_KA_WAIT;
            ST_KA_WAIT:    if (status.mul_done) state_next = ST_CHECK;
            ST_CHECK:      state_next = ST_DECIDE;
            ST_DECIDE:     state_next = status.plastic ? ST_GAM_GO : ST_ELASTIC;
            ST_GAM_GO:     state_next = ST_GAM_WAIT;
            ST_GAM_WAIT:   if (status.div_done) state_next = ST_DS_GO;
            ST_DS_GO:      state_next = ST_DS_WAIT;
            ST_DS_WAIT:    if (status.mul_done) state_next = ST_DB_GO;
            ST_DB_GO:      state_next = ST_DB_WAIT;
            ST_DB_WAIT:    if (status.mul_done) state_next = ST_TM_GO;
            ST_TM_GO:      state_next = ST_TM_WAIT;
            ST_TM_WAIT:    if (status.mul_done) state_next = ST_TD_GO;
            ST_TD_GO:      state_next = ST_TD_WAIT;
            ST_TD_WAIT:    if (status.div_done) state_next = ST_FINISH;
            ST_ELASTIC:    state_next = ST_FINISH;
            ST_MODE:       state_next = ST_FINISH;
            ST_FINISH:     if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_CAPTURE;
            end
            ST_TRIAL_GO:   cmd.op = OP_MUL_TRIAL;
            ST_TRIAL_WAIT: if (status.mul_done) cmd.op = OP_SAVE_TRIAL;
            ST_KA_GO:      cmd.op = OP_MUL_KA;
            ST_KA_WAIT:    if (status.mul_done) cmd.op = OP_SAVE_KA;
            ST_CHECK:      cmd.op = OP_CHECK;
            ST_GAM_GO:     cmd.op = OP_DIV_GAM;
            ST_GAM_WAIT:   if (status.div_done) cmd.op = OP_SAVE_GAM;
            ST_DS_GO:      cmd.op = OP_MUL_DS;
            ST_DS_WAIT:    if (status.mul_done) cmd.op = OP_SAVE_DS;
            ST_DB_GO:      cmd.op = OP_MUL_DB;
            ST_DB_WAIT:    if (status.mul_done) cmd.op = OP_SAVE_DB;
            ST_TM_GO:      cmd.op = OP_MUL_TAN;
            ST_TD_GO:      cmd.op = OP_DIV_TAN;
            ST_TD_WAIT:    if (status.div_done) cmd.op = OP_PLASTIC;
            ST_ELASTIC:    cmd.op = OP_ELASTIC;
            ST_MODE:       cmd.op = OP_MODE;
            ST_FINISH:     if (!out_valid_reg || m_tready) cmd.op = OP_OUT_LOAD;
            default:       cmd.op = OP_NONE;
        endcase
    end

    assign loading = (cmd.op == OP_OUT_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (loading) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
endmodule
`default_nettype wire

[rtl/prm1d_dp.sv]
// Datapath: material registers, state, intermediates, shared multiplier and divider.
// Depends on prm1d_pkg, prm1d_mul and prm1d_div.
`default_nettype none
module prm1d_dp (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [46:0]              cfg_data,
    input  wire logic [1:0]               in_mode,
    input  wire logic [31:0]              in_strain,
    input  wire prm1d_pkg::cmd_t          cmd,
    output prm1d_pkg::status_t            status,
    output logic [prm1d_pkg::OUT_W-1:0]   out_data,
    output logic                          out_yielded
);
    import prm1d_pkg::*;

    // Material registers.
    logic [46:0] e_reg, k_reg, h_reg, ys_reg;
    // Current and saved state.
    logic [31:0] cur_strain_reg, cur_ps_reg, cur_alpha_reg;
    logic [47:0] cur_stress_reg, cur_bs_reg;
    logic [46:0] cur_tan_reg;
    logic [31:0] sav_strain_reg, sav_ps_reg, sav_alpha_reg;
    logic [47:0] sav_stress_reg, sav_bs_reg;
    logic [46:0] sav_tan_reg;
    // Per-item intermediates.
    mode_t       mode_reg;
    logic [31:0] strain_reg, gamma_reg;
    logic        diff_neg_reg, rel_neg_reg, plastic_reg, yielded_reg;
    logic [32:0] mag_reg;
    logic [48:0] denom_reg, ds_reg, db_reg;
    logic [47:0] kh_reg, trial_reg, absrel_reg, uf_reg;
    logic [50:0] ka_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic        out_yielded_reg;

    logic [47:0] mul_a, mul_b;
    logic        mul_start, mul_done, div_start, div_done;
    logic [95:0] prod, quot, div_n;
    logic [32:0] diff;
    logic [47:0] trial_n;
    logic [50:0] ka_n;
    logic [48:0] rel;
    logic [53:0] f;
    logic [49:0] stress_sum, bs_sum;
    logic [33:0] ps_sum;
    logic [32:0] alpha_sum;

    prm1d_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
    );

    prm1d_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_n), .divisor(denom_reg), .done(div_done), .quot(quot)
    );

    always_comb begin
        mul_start = 1'b1;
        mul_a     = {1'b0, e_reg};
        mul_b     = '0;
        case (cmd.op)
            OP_MUL_TRIAL: mul_b = {15'd0, mag_reg};
            OP_MUL_KA: begin
                mul_a = {1'b0, k_reg};
                mul_b = {16'd0, cur_alpha_reg};
            end
            OP_MUL_DS:  mul_b = {16'd0, gamma_reg};
            OP_MUL_DB: begin
                mul_a = {1'b0, h_reg};
                mul_b = {16'd0, gamma_reg};
            end
            OP_MUL_TAN: mul_b = kh_reg;
            default:    mul_start = 1'b0;
        endcase
        div_start = (cmd.op == OP_DIV_GAM) || (cmd.op == OP_DIV_TAN);
        div_n     = (cmd.op == OP_DIV_GAM) ? {20'd0, uf_reg, 28'd0} : prod;
    end

    always_comb begin
        diff = {in_strain[31], in_strain} - {cur_ps_reg[31], cur_ps_reg};
        if (diff_neg_reg) begin
            trial_n = (|prod[95:75]) ? {1'b1, 47'd0} : 48'(48'd0 - {1'b0, prod[74:28]});
        end else begin
            trial_n = (|prod[95:75]) ? {1'b0, {47{1'b1}}} : {1'b0, prod[74:28]};
        end
        ka_n = ((|prod[95:79]) || (prod[78:28] > {1'b1, 50'd0})) ? {1'b1, 50'd0}
                                                                  : prod[78:28];
        rel = {trial_reg[47], trial_reg} - {cur_bs_reg[47], cur_bs_reg};
        f   = {6'd0, absrel_reg} - {7'd0, ys_reg} - {3'd0, ka_reg};
        stress_sum = {{2{trial_reg[47]}}, trial_reg}
                   + (rel_neg_reg ? {1'b0, ds_reg} : 50'(50'd0 - {1'b0, ds_reg}));
        bs_sum     = {{2{cur_bs_reg[47]}}, cur_bs_reg}
                   + (rel_neg_reg ? 50'(50'd0 - {1'b0, db_reg}) : {1'b0, db_reg});
        ps_sum     = {{2{cur_ps_reg[31]}}, cur_ps_reg}
                   + (rel_neg_reg ? 34'(34'd0 - {2'd0, gamma_reg}) : {2'd0, gamma_reg});
        alpha_sum  = {1'b0, cur_alpha_reg} + {1'b0, gamma_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg  <= 47'd65536;
            k_reg  <= '0;
            h_reg  <= '0;
            ys_reg <= 47'd65536;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ELASTIC: e_reg  <= cfg_data;
                CFG_ISO:     k_reg  <= cfg_data;
                CFG_KIN:     h_reg  <= cfg_data;
                CFG_YIELD:   ys_reg <= cfg_data;
                default:     e_reg  <= e_reg;
            endcase
        end
    end

    // Material state is architectural, so it is cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_strain_reg <= '0; cur_stress_reg <= '0; cur_ps_reg <= '0;
            cur_bs_reg     <= '0; cur_alpha_reg  <= '0; cur_tan_reg <= 47'd65536;
            sav_strain_reg <= '0; sav_stress_reg <= '0; sav_ps_reg <= '0;
            sav_bs_reg     <= '0; sav_alpha_reg  <= '0; sav_tan_reg <= 47'd65536;
        end else begin
            case (cmd.op)
                OP_ELASTIC: begin
                    cur_strain_reg <= strain_reg;
                    cur_stress_reg <= trial_reg;
                    cur_tan_reg    <= e_reg;
                end
                OP_PLASTIC: begin
                    cur_strain_reg <= strain_reg;
                    cur_stress_reg <= sat50_48(stress_sum);
                    cur_bs_reg     <= sat50_48(bs_sum);
                    cur_ps_reg     <= sat34_32(ps_sum);
                    cur_alpha_reg  <= alpha_sum[32] ? {32{1'b1}} : alpha_sum[31:0];
                    cur_tan_reg    <= (|quot[95:47]) ? {47{1'b1}} : quot[46:0];
                end
                OP_MODE: begin
                    case (mode_reg)
                        MODE_COMMIT: begin
                            sav_strain_reg <= cur_strain_reg; sav_stress_reg <= cur_stress_reg;
                            sav_ps_reg     <= cur_ps_reg;     sav_bs_reg     <= cur_bs_reg;
                            sav_alpha_reg  <= cur_alpha_reg;  sav_tan_reg    <= cur_tan_reg;
                        end
                        MODE_REVERSE: begin
                            cur_strain_reg <= sav_strain_reg; cur_stress_reg <= sav_stress_reg;
                            cur_ps_reg     <= sav_ps_reg;     cur_bs_reg     <= sav_bs_reg;
                            cur_alpha_reg  <= sav_alpha_reg;  cur_tan_reg    <= sav_tan_reg;
                        end
                        MODE_INITIAL: begin
                            cur_strain_reg <= '0; cur_stress_reg <= '0; cur_ps_reg <= '0;
                            cur_bs_reg     <= '0; cur_alpha_reg  <= '0; cur_tan_reg <= e_reg;
                            sav_strain_reg <= '0; sav_stress_reg <= '0; sav_ps_reg <= '0;
                            sav_bs_reg     <= '0; sav_alpha_reg  <= '0; sav_tan_reg <= e_reg;
                        end
                        default: cur_tan_reg <= cur_tan_reg;
                    endcase
                end
                default: cur_tan_reg <= cur_tan_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yielded_reg     <= 1'b0;
            plastic_reg     <= 1'b0;
            out_yielded_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_CAPTURE) yielded_reg <= 1'b0;
            if (cmd.op == OP_PLASTIC) yielded_reg <= 1'b1;
            if (cmd.op == OP_CHECK) begin
                plastic_reg <= !f[53] && (f != 54'd0) && (denom_reg != 49'd0);
            end
            if (cmd.op == OP_OUT_LOAD) out_yielded_reg <= yielded_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                mode_reg     <= mode_t'(in_mode);
                strain_reg   <= in_strain;
                diff_neg_reg <= diff[32];
                mag_reg      <= diff[32] ? 33'(33'd0 - diff) : diff;
                denom_reg    <= {2'd0, e_reg} + {2'd0, k_reg} + {2'd0, h_reg};
                kh_reg       <= {1'b0, k_reg} + {1'b0, h_reg};
            end
            OP_SAVE_TRIAL: trial_reg <= trial_n;
            OP_SAVE_KA: begin
                ka_reg      <= ka_n;
                rel_neg_reg <= rel[48];
                absrel_reg  <= rel[48] ? 48'(49'd0 - rel) : rel[47:0];
            end
            OP_CHECK:    uf_reg    <= f[47:0];
            OP_SAVE_GAM: gamma_reg <= (|quot[95:32]) ? {32{1'b1}} : quot[31:0];
            OP_SAVE_DS:  ds_reg    <= shr28_cap48(prod);
            OP_SAVE_DB:  db_reg    <= shr28_cap48(prod);
            OP_OUT_LOAD: out_data_reg <= {1'b0, cur_alpha_reg, cur_bs_reg, cur_ps_reg,
                                          cur_tan_reg, cur_stress_reg};
            default:     out_data_reg <= out_data_reg;
        endcase
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.plastic  = plastic_reg;
    assign out_data        = out_data_reg;
    assign out_yielded     = out_yielded_reg;
endmodule
`default_nettype wire
